>>> src/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that the consequent holds in the cycle the antecedent holds.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/lruk_pkg.sv
`default_nettype none

package lruk_pkg;

  localparam int PAGE_ID_W   = 16;
  localparam int FAULT_W     = 32;
  localparam int CFG_W       = 5;
  localparam int KTH_W       = 4;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 3 + PAGE_ID_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LIMIT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_K_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_LIMIT_RST = 5'd16;
  localparam logic [KTH_W-1:0] K_THRESHOLD_RST = 4'd2;

  // Per-cell control from the top level.
  typedef struct packed {
    logic upd;  // chain update cycle
    logic rem;  // this cell holds the entry that leaves its place
  } lruk_cell_ctrl_t;

  // Per-cell status back to the top level.
  typedef struct packed {
    logic valid;
    logic hot;
    logic match;
    logic last_cold;
  } lruk_cell_stat_t;

endpackage

`default_nettype wire

>>> src/lruk_cell.sv
`default_nettype none

// One position of the recency chain. Position 0 is the most recent page.
module lruk_cell #(
  parameter int PAGE_WIDTH = 16,
  parameter int REF_W      = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lruk_pkg::lruk_cell_ctrl_t ctrl_i,
  input  logic [PAGE_WIDTH-1:0]    cmp_page_i,
  input  logic                     prev_valid_i,
  input  logic                     prev_hot_i,
  input  logic [REF_W-1:0]         prev_refs_i,
  input  logic [PAGE_WIDTH-1:0]    prev_page_i,
  input  logic                     shift_in_i,
  input  logic                     cold_after_i,
  output logic [REF_W-1:0]         refs_o,
  output logic [PAGE_WIDTH-1:0]    page_o,
  output logic                     shift_o,
  output logic                     cold_o,
  output lruk_pkg::lruk_cell_stat_t stat_o
);
  import lruk_pkg::*;

  logic                  valid_q, valid_d;
  logic                  hot_q, hot_d;
  logic [REF_W-1:0]      refs_q, refs_d;
  logic [PAGE_WIDTH-1:0] page_q, page_d;
  logic                  load;
  logic                  cold_here;
  lruk_cell_stat_t       stat;

  // A cell takes its neighbor's entry when the removed position is here or further back.
  assign shift_o   = ctrl_i.rem | shift_in_i;
  assign load      = ctrl_i.upd & shift_o;
  assign cold_here = valid_q & ~hot_q;
  assign cold_o    = cold_here | cold_after_i;

  always_comb begin
    valid_d = valid_q;
    hot_d   = hot_q;
    refs_d  = refs_q;
    page_d  = page_q;
    if (load) begin
      valid_d = prev_valid_i;
      hot_d   = prev_hot_i;
      refs_d  = prev_refs_i;
      page_d  = prev_page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hot_q  <= hot_d;
    refs_q <= refs_d;
    page_q <= page_d;
  end

  always_comb begin
    stat.valid     = valid_q;
    stat.hot       = hot_q;
    stat.match     = valid_q & (page_q == cmp_page_i);
    stat.last_cold = cold_here & ~cold_after_i;
  end

  assign stat_o = stat;
  assign refs_o = refs_q;
  assign page_o = page_q;

endmodule

`default_nettype wire

>>> src/lru_k_page_replacement_unit.sv
// A result is registered at the chain update, once the result register is free.
// A new page request is taken only while idle: its match across the cell chain
//   is captured on accept, and the chain shift that reorders it follows.
// Reset: asynchronous, active low; the store comes up empty, the fault total is
//   zero, frame_limit is 16 and k_threshold is 2. No clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module lru_k_page_replacement_unit #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_WIDTH  = 16,
  parameter int REF_LIMIT   = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [lruk_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [lruk_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Page request stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lruk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] page_id
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] hit, [1] evicted_valid, [17:2] evicted_page, [18] now_hot,
  // [50:19] fault_count, [55:51] zero
  output logic [lruk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import lruk_pkg::*;

  localparam int OCC_W = $clog2(FRAME_SLOTS + 1);
  localparam int REF_W = (REF_LIMIT > 1) ? $clog2(REF_LIMIT + 1) : 1;
  localparam int CMP_W = (REF_W > KTH_W) ? REF_W : KTH_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  // Sequencer: a request is matched against the chain at its accept edge and
  // the chain is reordered in the update state, once the result register is free.
  logic state_q, state_d;
  logic accept;
  logic go;

  logic [CFG_W-1:0] frame_limit_q, frame_limit_d;
  logic [KTH_W-1:0] k_q, k_d;

  logic [PAGE_WIDTH-1:0]  page_in;
  logic [PAGE_WIDTH-1:0]  page_q, page_d;
  logic [FRAME_SLOTS-1:0] match_q, match_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [FAULT_W-1:0]     fault_q, fault_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic                   out_ev_valid_q, out_ev_valid_d;
  logic [PAGE_ID_W-1:0]   out_ev_page_q, out_ev_page_d;
  logic                   out_hot_q, out_hot_d;

  // Chain views.
  logic [FRAME_SLOTS-1:0] v_valid, v_hot, v_match, v_last_cold;
  logic [FRAME_SLOTS-1:0] v_shift, v_cold, v_rem, v_victim;
  logic [FRAME_SLOTS-1:0] v_last_valid, v_first_free;
  logic [REF_W-1:0]       c_refs [FRAME_SLOTS];
  logic [PAGE_WIDTH-1:0]  c_page [FRAME_SLOTS];
  lruk_cell_stat_t        c_stat [FRAME_SLOTS];
  lruk_cell_ctrl_t        c_ctrl [FRAME_SLOTS];

  // Derived request values.
  logic                   hit;
  logic                   evict;
  logic [OCC_W-1:0]       limit;
  logic [KTH_W-1:0]       keff;
  logic [CMP_W-1:0]       keff_c, cap_c, refs_c, refs_new_c;
  logic [REF_W-1:0]       hit_refs;
  logic [PAGE_WIDTH-1:0]  ev_page;
  logic                   hit_hot;
  logic                   head_hot;
  logic [REF_W-1:0]       head_refs;

  assign page_in       = PAGE_WIDTH'(s_axis_tdata[PAGE_ID_W-1:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign go            = (state_q == ST_UPD) & (~out_valid_q | m_axis_tready);

  // Configuration registers; writes are to arrive only while the unit is idle, which the block does not enforce.
  always_comb begin
    frame_limit_d = frame_limit_q;
    k_d           = k_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FRAME_LIMIT: frame_limit_d = cfg_wdata_i;
        CFG_K_THRESHOLD: k_d           = cfg_wdata_i[KTH_W-1:0];
      endcase
    end
  end

  // A zero limit acts as one frame, and a limit above the slot count saturates.
  always_comb begin
    if (frame_limit_q == '0) begin
      limit = OCC_W'(1);
    end else if (32'(frame_limit_q) > FRAME_SLOTS) begin
      limit = OCC_W'(FRAME_SLOTS);
    end else begin
      limit = OCC_W'(frame_limit_q);
    end
  end

  // A zero threshold acts as one; counts saturate at the smaller of K and REF_LIMIT.
  assign keff   = (k_q == '0) ? KTH_W'(1) : k_q;
  assign keff_c = CMP_W'(keff);
  assign cap_c  = (keff_c < CMP_W'(REF_LIMIT)) ? keff_c : CMP_W'(REF_LIMIT);

  // The chain keeps one recency order for all resident pages, each marked hot
  // or cold. Each class's own order is the chain order restricted to that class,
  // so the least recent cold page is the last cold cell, and when no cold page
  // is resident the least recent hot page is simply the last valid cell.
  for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
    logic                  prev_valid;
    logic                  prev_hot;
    logic [REF_W-1:0]      prev_refs;
    logic [PAGE_WIDTH-1:0] prev_page;
    logic                  shift_in;
    logic                  cold_after;

    if (g == 0) begin : g_head
      assign prev_valid      = 1'b1;
      assign prev_hot        = head_hot;
      assign prev_refs       = head_refs;
      assign prev_page       = page_q;
      assign v_first_free[g] = ~v_valid[g];
    end else begin : g_body
      assign prev_valid      = v_valid[g-1];
      assign prev_hot        = v_hot[g-1];
      assign prev_refs       = c_refs[g-1];
      assign prev_page       = c_page[g-1];
      assign v_first_free[g] = ~v_valid[g] & v_valid[g-1];
    end

    if (g == FRAME_SLOTS - 1) begin : g_tail
      assign shift_in        = 1'b0;
      assign cold_after      = 1'b0;
      assign v_last_valid[g] = v_valid[g];
    end else begin : g_inner
      assign shift_in        = v_shift[g+1];
      assign cold_after      = v_cold[g+1];
      assign v_last_valid[g] = v_valid[g] & ~v_valid[g+1];
    end

    assign c_ctrl[g].upd = go;
    assign c_ctrl[g].rem = v_rem[g];

    lruk_cell #(
      .PAGE_WIDTH(PAGE_WIDTH),
      .REF_W     (REF_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (c_ctrl[g]),
      .cmp_page_i  (page_in),
      .prev_valid_i(prev_valid),
      .prev_hot_i  (prev_hot),
      .prev_refs_i (prev_refs),
      .prev_page_i (prev_page),
      .shift_in_i  (shift_in),
      .cold_after_i(cold_after),
      .refs_o      (c_refs[g]),
      .page_o      (c_page[g]),
      .shift_o     (v_shift[g]),
      .cold_o      (v_cold[g]),
      .stat_o      (c_stat[g])
    );

    assign v_valid[g]     = c_stat[g].valid;
    assign v_hot[g]       = c_stat[g].hot;
    assign v_match[g]     = c_stat[g].match;
    assign v_last_cold[g] = c_stat[g].last_cold;
  end

  assign hit      = |match_q;
  assign evict    = ~hit & (occ_q >= limit);
  assign v_victim = v_cold[0] ? v_last_cold : v_last_valid;

  // The removed position: the hit page, the victim, or the first free cell.
  // Every cell from the head down to it shifts back by one.
  assign v_rem = hit ? match_q : (evict ? v_victim : v_first_free);

  always_comb begin
    hit_refs = '0;
    ev_page  = '0;
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      hit_refs = hit_refs | (c_refs[i] & {REF_W{match_q[i]}});
      ev_page  = ev_page | (c_page[i] & {PAGE_WIDTH{v_victim[i]}});
    end
  end

  assign refs_c     = CMP_W'(hit_refs);
  assign refs_new_c = (refs_c < cap_c) ? refs_c + CMP_W'(1) : refs_c;
  assign hit_hot    = (refs_new_c >= keff_c);

  // A new page enters with one reference, hot only when K is zero or one.
  assign head_hot  = hit ? hit_hot : (keff == KTH_W'(1));
  assign head_refs = hit ? REF_W'(refs_new_c) : REF_W'(1);

  always_comb begin
    state_d        = state_q;
    page_d         = page_q;
    match_d        = match_q;
    occ_d          = occ_q;
    fault_d        = fault_q;
    out_valid_d    = out_valid_q & ~m_axis_tready;
    out_hit_d      = out_hit_q;
    out_ev_valid_d = out_ev_valid_q;
    out_ev_page_d  = out_ev_page_q;
    out_hot_d      = out_hot_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          page_d  = page_in;
          match_d = v_match;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (go) begin
          state_d        = ST_IDLE;
          out_valid_d    = 1'b1;
          out_hit_d      = hit;
          out_ev_valid_d = evict;
          out_ev_page_d  = evict ? PAGE_ID_W'(ev_page) : '0;
          out_hot_d      = head_hot;
          if (!hit) begin
            fault_d = fault_q + FAULT_W'(1);
            if (!evict) begin
              occ_d = occ_q + OCC_W'(1);
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_limit_q <= FRAME_LIMIT_RST;
      k_q           <= K_THRESHOLD_RST;
      occ_q         <= '0;
      fault_q       <= '0;
      out_valid_q   <= 1'b0;
      match_q       <= '0;
    end else begin
      state_q       <= state_d;
      frame_limit_q <= frame_limit_d;
      k_q           <= k_d;
      occ_q         <= occ_d;
      fault_q       <= fault_d;
      out_valid_q   <= out_valid_d;
      match_q       <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q         <= page_d;
    out_hit_q      <= out_hit_d;
    out_ev_valid_q <= out_ev_valid_d;
    out_ev_page_q  <= out_ev_page_d;
    out_hot_q      <= out_hot_d;
  end

  // The fault total only moves when a result is loaded, so it is shown directly.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, fault_q, out_hot_q, out_ev_page_q,
                          out_ev_valid_q, out_hit_q};

  // The occupancy counter tracks the number of valid cells.
  `ASSERT_ALWAYS(a_occ_count, clk_i, rst_ni, 32'(occ_q) == $countones(v_valid),
                 "occupancy counter disagrees with chain")
  // Valid cells stay packed toward the head of the chain.
  `ASSERT_ALWAYS(a_packed, clk_i, rst_ni, (v_valid & (v_valid + FRAME_SLOTS'(1))) == '0,
                 "hole in the recency chain")
  // A page is resident in at most one cell.
  `ASSERT_ALWAYS(a_match_unique, clk_i, rst_ni, $onehot0(match_q),
                 "page matched in more than one cell")
  // Exactly one position leaves the chain on each update.
  `ASSERT_IMPLIES(a_rem_onehot, clk_i, rst_ni, state_q == ST_UPD, $onehot(v_rem),
                  "chain removal position is not unique")

endmodule

`default_nettype wire
